// ----- hdl/sist_pkg.sv -----
// Shared constants and command codes for the sorted integer set table.
`default_nettype none
package sist_pkg;

    localparam int NUM_SETS     = 4;
    localparam int SET_CAPACITY = 256;

    localparam int SEL_W  = 4;
    localparam int EN_W   = 4;
    localparam int KEY_W  = 32;
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int POS_W  = $clog2(SET_CAPACITY);
    localparam int CNT_W  = POS_W + 1;
    localparam int ADDR_W = SET_W + POS_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

endpackage
`default_nettype wire

// ----- hdl/sorted_integer_set_table_core.sv -----
// Top level of the sorted integer set table: control, set counts and result register.
//
// Keeps NUM_SETS sorted, duplicate-free sets of signed 32-bit values in one
// single-port-read, single-port-write RAM. Each item runs a binary search, each
// probe a RAM read and then a compare; an insert of a new value or a remove of a
// present one then moves the tail of the set one entry per cycle through the RAM.
// Query, clear and commands to a disabled set finish within the search or at once.
// A new item is accepted while the previous result waits in the output register.
// No clearing pass is needed after reset: set counts reset to zero.
`default_nettype none
module sorted_integer_set_table_core
    import sist_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [EN_W-1:0]  cfg_write_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       command,
    input  wire logic [SEL_W-1:0] set_index,
    input  wire logic [KEY_W-1:0] value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  ok,
    output logic                  full_error
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [SEL_W:0]   SET_LIM = (SEL_W + 1)'(NUM_SETS);
    localparam logic [CNT_W-1:0] CAP     = CNT_W'(SET_CAPACITY);

    logic [2:0]       state_reg, state_next;
    logic [EN_W-1:0]  enabled_reg;
    logic [1:0]       cmd_reg, cmd_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [POS_W-1:0] mid_reg, mid_next;
    logic             found_reg, found_next;
    logic             up_reg, up_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic             pend_reg, pend_next;
    logic [POS_W-1:0] pend_pos_reg, pend_pos_next;
    logic             res_ok_reg, res_ok_next;
    logic             res_full_reg, res_full_next;
    logic             out_valid_reg, out_valid_next;
    logic             ok_reg, ok_next;
    logic             full_reg, full_next;
    logic [CNT_W-1:0] count_reg [NUM_SETS];
    logic [CNT_W-1:0] count_next [NUM_SETS];

    logic [15:0]       en_ext;
    logic              set_ok;
    logic [SET_W-1:0]  in_set;
    logic [CNT_W-1:0]  n_cur;
    logic [CNT_W-1:0]  mid_sum;
    logic              more;
    logic              we;
    logic [POS_W-1:0]  wpos;
    logic [KEY_W-1:0]  wdata;
    logic [POS_W-1:0]  rpos;
    logic [KEY_W-1:0]  rdata;

    assign en_ext  = {{(16 - EN_W){1'b0}}, enabled_reg};
    assign set_ok  = ({1'b0, set_index} < SET_LIM) && en_ext[set_index];
    assign in_set  = set_index[SET_W-1:0];
    assign n_cur   = count_reg[set_reg];
    assign mid_sum = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign more    = up_reg ? (cur_reg > lo_reg) : (cur_reg < n_cur);

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign full_error = full_reg;

    sist_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr ({set_reg, wpos}),
        .wdata (wdata),
        .raddr ({set_reg, rpos}),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        set_next       = set_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        found_next     = found_reg;
        up_next        = up_reg;
        cur_next       = cur_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        res_ok_next    = res_ok_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        ok_next        = ok_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        we             = 1'b0;
        wpos           = pend_pos_reg;
        wdata          = rdata;
        rpos           = mid_sum[POS_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    set_next   = in_set;
                    key_next   = value;
                    lo_next    = '0;
                    hi_next    = count_reg[in_set];
                    found_next = 1'b0;
                    if (!set_ok)
                    begin
                        res_ok_next   = 1'b0;
                        res_full_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else if (command == CMD_CLEAR)
                    begin
                        count_next[in_set] = '0;
                        res_ok_next        = 1'b1;
                        res_full_next      = 1'b0;
                        state_next         = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[POS_W-1:0];
                    state_next = ST_CMP;
                end
                else
                begin
                    res_ok_next   = 1'b1;
                    res_full_next = 1'b0;
                    state_next    = ST_DONE;
                    case (cmd_reg)
                        CMD_QUERY:
                        begin
                            res_ok_next = found_reg;
                        end
                        CMD_INSERT:
                        begin
                            if (!found_reg)
                            begin
                                if (n_cur >= CAP)
                                begin
                                    res_ok_next   = 1'b0;
                                    res_full_next = 1'b1;
                                end
                                else
                                begin
                                    up_next    = 1'b1;
                                    cur_next   = n_cur;
                                    pend_next  = 1'b0;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                up_next    = 1'b0;
                                cur_next   = lo_reg + 1'b1;
                                pend_next  = 1'b0;
                                state_next = ST_SHIFT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if ($signed(rdata) < $signed(key_reg))
                begin
                    lo_next = {1'b0, mid_reg} + 1'b1;
                end
                else
                begin
                    hi_next    = {1'b0, mid_reg};
                    found_next = (rdata == key_reg);
                end
                state_next = ST_SRCH;
            end
            ST_SHIFT:
            begin
                pend_next = more;
                if (pend_reg)
                begin
                    we = 1'b1;
                end
                if (more)
                begin
                    if (up_reg)
                    begin
                        rpos          = POS_W'(cur_reg - 1'b1);
                        pend_pos_next = cur_reg[POS_W-1:0];
                        cur_next      = cur_reg - 1'b1;
                    end
                    else
                    begin
                        rpos          = cur_reg[POS_W-1:0];
                        pend_pos_next = POS_W'(cur_reg - 1'b1);
                        cur_next      = cur_reg + 1'b1;
                    end
                end
                else if (!pend_reg)
                begin
                    if (up_reg)
                    begin
                        we                  = 1'b1;
                        wpos                = lo_reg[POS_W-1:0];
                        wdata               = key_reg;
                        count_next[set_reg] = n_cur + 1'b1;
                    end
                    else
                    begin
                        count_next[set_reg] = n_cur - 1'b1;
                    end
                    res_ok_next   = 1'b1;
                    res_full_next = 1'b0;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    full_next      = res_full_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enabled_reg   <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            for (int i = 0; i < NUM_SETS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            if (cfg_write_en)
            begin
                enabled_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        set_reg      <= set_next;
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        found_reg    <= found_next;
        up_reg       <= up_next;
        cur_reg      <= cur_next;
        pend_pos_reg <= pend_pos_next;
        res_ok_reg   <= res_ok_next;
        res_full_reg <= res_full_next;
        ok_reg       <= ok_next;
        full_reg     <= full_next;
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> count_reg[set_reg] <= CAP)
        else $error("set count above capacity");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != ST_IDLE)
        else $error("accepted item did not start");

    a_ok_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(ok_reg && full_reg))
        else $error("ok and full_error both set");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT && up_reg |-> cur_reg >= lo_reg)
        else $error("insert shift ran past the insert position");
`endif

endmodule
`default_nettype wire

// ----- hdl/sist_ram.sv -----
// Value store: one write port, one read port, registered read data.
`default_nettype none
module sist_ram
    import sist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [KEY_W-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [KEY_W-1:0]  rdata
);

    logic [KEY_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- verif/sist_checker.sv -----
// Checker for the sorted integer set table: tracks the sets, predicts each result, compares.
`timescale 1ns / 100ps
module sist_checker
    import sist_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [EN_W-1:0]  cfg_write_data,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire logic [1:0]       command,
    input  wire logic [SEL_W-1:0] set_index,
    input  wire logic [KEY_W-1:0] value,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic             ok,
    input  wire logic             full_error,
    output int                    items_in,
    output int                    results_out,
    output int                    mismatches
);

    typedef struct packed {
        logic ok;
        logic full_error;
    } outcome_t;

    logic [KEY_W-1:0] members [NUM_SETS][SET_CAPACITY];
    int               fill_level [NUM_SETS];
    logic [EN_W-1:0]  open_mask;
    outcome_t         pending_outcomes [$];

    task automatic report_mismatch(input string msg);
        if (mismatches < 20)
            $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic outcome_t apply_command(input logic [1:0] cmd,
                                               input logic [SEL_W-1:0] sel,
                                               input logic [KEY_W-1:0] key);
        outcome_t r;
        int       s;
        int       n;
        int       lo;
        int       hi;
        int       mid;
        int       j;
        bit       hit;
        r = '0;
        if (sel < NUM_SETS && open_mask[sel])
        begin
            s  = sel;
            n  = fill_level[s];
            lo = 0;
            hi = n;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if ($signed(members[s][mid]) < $signed(key))
                    lo = mid + 1;
                else
                    hi = mid;
            end
            hit = (lo < n) && (members[s][lo] == key);
            case (cmd)
                CMD_INSERT:
                begin
                    if (hit)
                        r.ok = 1'b1;
                    else if (n >= SET_CAPACITY)
                        r.full_error = 1'b1;
                    else
                    begin
                        for (j = n; j > lo; j--)
                            members[s][j] = members[s][j-1];
                        members[s][lo] = key;
                        fill_level[s] = n + 1;
                        r.ok = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (hit)
                    begin
                        for (j = lo; j < n - 1; j++)
                            members[s][j] = members[s][j+1];
                        fill_level[s] = n - 1;
                    end
                    r.ok = 1'b1;
                end
                CMD_QUERY:
                    r.ok = hit;
                default:
                begin
                    fill_level[s] = 0;
                    r.ok = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SETS; i++)
                fill_level[i] = 0;
            open_mask = '0;
            pending_outcomes.delete();
            mismatches = 0;
            items_in    <= 0;
            results_out <= 0;
        end
        else
        begin
            if (cfg_write_en)
                open_mask = cfg_write_data;
            if (in_valid && in_ready)
            begin
                pending_outcomes.push_back(apply_command(command, set_index, value));
                items_in <= items_in + 1;
            end
            if (out_valid && out_ready)
            begin
                results_out <= results_out + 1;
                if (pending_outcomes.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (ok !== want.ok)
                        report_mismatch($sformatf("ok got %b expected %b", ok, want.ok));
                    if (full_error !== want.full_error)
                        report_mismatch($sformatf("full_error got %b expected %b",
                                                  full_error, want.full_error));
                end
            end
        end
    end

endmodule

// ----- verif/tb_sorted_integer_set_table_core.sv -----
// Testbench top for the sorted integer set table: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 100ps
module tb_sorted_integer_set_table_core
    import sist_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 300;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             cfg_write_en   = 1'b0;
    logic [EN_W-1:0]  cfg_write_data = '0;
    logic             in_valid       = 1'b0;
    logic             in_ready;
    logic [1:0]       command        = CMD_QUERY;
    logic [SEL_W-1:0] set_index      = '0;
    logic [KEY_W-1:0] value          = '0;
    logic             out_valid;
    logic             out_ready      = 1'b0;
    logic             ok;
    logic             full_error;

    int items_in;
    int results_out;
    int mismatches;

    int send_pct    = 0;
    int recv_pct    = 0;
    bit hold_arm    = 1'b0;
    bit hold_seen   = 1'b0;
    int hold_left   = 0;
    int quiet_count = 0;

    logic [KEY_W-1:0] fill_keys [SET_CAPACITY];

    sorted_integer_set_table_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .set_index      (set_index),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .full_error     (full_error)
    );

    sist_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .set_index      (set_index),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .full_error     (full_error),
        .items_in       (items_in),
        .results_out    (results_out),
        .mismatches     (mismatches)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off whenever hold_arm toggles
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm != hold_seen)
        begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 42)
            return CMD_INSERT;
        else if (r < 64)
            return CMD_REMOVE;
        else if (r < 97)
            return CMD_QUERY;
        return CMD_CLEAR;
    endfunction

    function automatic logic [SEL_W-1:0] pick_set();
        if ($urandom_range(99) < 88)
            return SEL_W'($urandom_range(NUM_SETS - 1));
        return SEL_W'($urandom_range(2**SEL_W - 1));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return {1'b1, {(KEY_W-1){1'b0}}};
        else if (r < 6)
            return {1'b0, {(KEY_W-1){1'b1}}};
        else if (r < 8)
            return '1;
        else if (r < 25)
            return KEY_W'($urandom);
        return KEY_W'($urandom_range(40)) - KEY_W'(20);
    endfunction

    task automatic set_pace(input int s_pct, input int r_pct);
        send_pct = s_pct;
        recv_pct <= r_pct;
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [SEL_W-1:0] sel,
                             input logic [KEY_W-1:0] key);
        if ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_pct)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        set_index <= sel;
        value     <= key;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (items_in != results_out)
            @(posedge clk);
    endtask

    task automatic write_enables(input logic [EN_W-1:0] mask);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= mask;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_item(pick_command(), pick_set(), pick_key());
    endtask

    task automatic fill_one_set();
        logic [SEL_W-1:0] fs;
        logic [POS_W-1:0] perm;
        int               k;
        fs   = SEL_W'($urandom_range(NUM_SETS - 1));
        perm = POS_W'($urandom);
        send_item(CMD_CLEAR, fs, '0);
        for (int i = 0; i < SET_CAPACITY; i++)
        begin
            fill_keys[i] = {POS_W'(i ^ perm), (KEY_W-POS_W)'($urandom)};
            send_item(CMD_INSERT, fs, fill_keys[i]);
            if (i == SET_CAPACITY / 2)
                hold_arm <= ~hold_arm;
        end
        // set is now full
        k = $urandom_range(SET_CAPACITY - 1);
        send_item(CMD_INSERT, fs, KEY_W'($urandom));
        send_item(CMD_INSERT, fs, fill_keys[k]);
        send_item(CMD_QUERY, fs, fill_keys[k]);
        send_item(CMD_REMOVE, fs, fill_keys[k]);
        send_item(CMD_QUERY, fs, fill_keys[k]);
        send_item(CMD_INSERT, fs, KEY_W'($urandom));
        send_item(CMD_INSERT, fs, KEY_W'($urandom));
        for (int i = 0; i < 12; i++)
        begin
            k = $urandom_range(SET_CAPACITY - 1);
            send_item(($urandom_range(1) != 0) ? CMD_REMOVE : CMD_INSERT, fs,
                      ($urandom_range(3) != 0) ? fill_keys[k] : KEY_W'($urandom));
            send_item(CMD_QUERY, fs, fill_keys[k]);
        end
        send_item(CMD_CLEAR, fs, '0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pace(0, 0);
        write_enables(4'hF);
        send_item(CMD_QUERY,  4'd0, 32'd0);
        send_item(CMD_INSERT, 4'd0, 32'h8000_0000);
        send_item(CMD_INSERT, 4'd0, 32'h7FFF_FFFF);
        send_item(CMD_INSERT, 4'd0, 32'd0);
        send_item(CMD_INSERT, 4'd0, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 4'd0, 32'd1);
        send_item(CMD_INSERT, 4'd0, 32'h7FFF_FFFF);
        send_item(CMD_QUERY,  4'd0, 32'h8000_0000);
        send_item(CMD_QUERY,  4'd0, 32'h7FFF_FFFE);
        send_item(CMD_REMOVE, 4'd0, 32'd5);
        send_item(CMD_REMOVE, 4'd0, 32'hFFFF_FFFF);
        send_item(CMD_QUERY,  4'd0, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 4'd3, 32'hA5A5_A5A5);
        send_item(CMD_QUERY,  4'd3, 32'hA5A5_A5A5);
        send_item(CMD_INSERT, 4'd4, 32'd7);
        send_item(CMD_QUERY,  4'hF, 32'd0);
        send_item(CMD_CLEAR,  4'hF, 32'd0);
        send_item(CMD_REMOVE, 4'd1, 32'd0);
        send_item(CMD_CLEAR,  4'd0, 32'd0);
        send_item(CMD_QUERY,  4'd0, 32'h7FFF_FFFF);
        send_item(CMD_INSERT, 4'd2, 32'h5A5A_5A5A);
        wait_results();

        write_enables(4'h0);
        run_random(6);
        wait_results();

        write_enables(4'b0101);
        set_pace(72, 0);
        run_random(60);
        wait_results();

        write_enables(4'hF);
        set_pace(0, 72);
        fill_one_set();
        wait_results();

        write_enables(EN_W'($urandom));
        set_pace(37, 37);
        run_random(130);
        wait_results();

        write_enables(4'b1010);
        set_pace(0, 72);
        run_random(130);
        wait_results();

        write_enables(4'hF);
        set_pace(72, 0);
        run_random(120);
        set_pace(0, 0);
        hold_arm <= ~hold_arm;
        run_random(120);
        wait_results();
        set_pace(37, 37);
        run_random(100);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && items_in == results_out)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
